[src/hcfp_pkg.sv]
// Package for the hex command frame parser.
// Holds result kinds, character constants, the result types and the hex decode function.
// No dependencies.
package hcfp_pkg;

  localparam int unsigned FRAME_LENGTH = 5;
  localparam int unsigned DIGIT_COUNT  = FRAME_LENGTH - 1;
  localparam int unsigned POS_W        = $clog2(FRAME_LENGTH);
  localparam int unsigned DIGIT_IDX_W  = $clog2(DIGIT_COUNT);

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [3:0] NIBBLE_TEN = 4'd10;

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_ECHO    = 2'd1,
    KIND_MISSED  = 2'd2,
    KIND_WRONG   = 2'd3
  } hcfp_kind_t;

  typedef struct packed {
    hcfp_kind_t  kind;
    logic [7:0]  cmd;
    logic [15:0] value;
    logic [39:0] frame;
    logic        last;
  } hcfp_result_t;

  typedef struct packed {
    logic [1:0]   count;
    hcfp_result_t first;
    hcfp_result_t second;
  } hcfp_step_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d_dig;
    logic [7:0] d_uc;
    logic [7:0] d_lc;
    logic [4:0] r;
    d_dig = c - CHAR_0;
    d_uc  = c - CHAR_UC_A;
    d_lc  = c - CHAR_LC_A;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      r = {1'b1, d_dig[3:0]};
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      r = {1'b1, NIBBLE_TEN + d_uc[3:0]};
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      r = {1'b1, NIBBLE_TEN + d_lc[3:0]};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

[src/hcfp_if.sv]
// Channel interfaces for the hex command frame parser: received bytes in, results out.
// Valid/ready handshake; no dependencies.
interface hcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  command_char;
  logic [15:0] command_value;
  logic [39:0] echo_frame;
  logic        last_of_run;

  modport source (output valid, output result_kind, output command_char,
                  output command_value, output echo_frame, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input command_char,
                  input command_value, input echo_frame, input last_of_run,
                  output ready);
endinterface

[src/hcfp_parse.sv]
// Frame tracker and parser: holds frame position and bytes, decodes one byte per step.
// Depends on hcfp_pkg.
module hcfp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  input  logic               echo_en,
  output hcfp_pkg::hcfp_step_t res
);
  import hcfp_pkg::*;

  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_nxt;
  logic [POS_W-1:0]       pos_eff;
  logic [POS_W-1:0]       pos_m1;
  logic [7:0]             cmd_r;
  logic [7:0]             digit_r [DIGIT_COUNT];
  logic [7:0]             dig     [DIGIT_COUNT];
  logic [4:0]             dec     [DIGIT_COUNT];
  logic [4:0]             byte_dec;
  logic                   all_ok;
  logic [15:0]            value;
  logic [DIGIT_IDX_W-1:0] widx;
  hcfp_result_t           parsed;
  hcfp_result_t           echo;

  assign pos_eff  = (pos_r >= POS_W'(FRAME_LENGTH)) ? '0 : pos_r;
  assign pos_m1   = pos_eff - POS_W'(1);
  assign widx     = pos_m1[DIGIT_IDX_W-1:0];
  assign byte_dec = hex_decode(rx_byte);

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
      dig[i] = digit_r[i];
    end
    dig[DIGIT_COUNT-1] = rx_byte;
    all_ok = 1'b1;
    value  = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      dec[i] = hex_decode(dig[i]);
      all_ok = all_ok & dec[i][4];
      value  = {value[11:0], dec[i][3:0]};
    end
  end

  always_comb begin
    echo.kind  = KIND_ECHO;
    echo.cmd   = cmd_r;
    echo.value = '0;
    echo.frame = {cmd_r, dig[0], dig[1], dig[2], dig[3]};
    echo.last  = 1'b0;
    parsed.value = '0;
    parsed.frame = '0;
    parsed.last  = 1'b1;
    if (all_ok) begin
      parsed.kind  = KIND_COMMAND;
      parsed.cmd   = cmd_r;
      parsed.value = value;
    end else begin
      parsed.kind = KIND_WRONG;
      parsed.cmd  = '0;
    end
  end

  always_comb begin
    res.count  = 2'd0;
    res.first  = parsed;
    res.second = parsed;
    pos_nxt    = pos_eff;
    if (pos_eff == '0) begin
      if (byte_dec[4]) begin
        res.count       = 2'd1;
        res.first.kind  = KIND_MISSED;
        res.first.cmd   = '0;
        res.first.value = '0;
        res.first.frame = '0;
        res.first.last  = 1'b1;
      end else begin
        pos_nxt = POS_W'(1);
      end
    end else if (pos_eff == POS_W'(FRAME_LENGTH - 1)) begin
      pos_nxt = '0;
      if (echo_en) begin
        res.count = 2'd2;
        res.first = echo;
      end else begin
        res.count = 2'd1;
      end
    end else begin
      pos_nxt = pos_eff + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (pos_eff == '0) begin
        if (!byte_dec[4]) begin
          cmd_r <= rx_byte;
        end
      end else begin
        digit_r[widx] <= rx_byte;
      end
    end
  end

endmodule

[src/hex_command_frame_parser_core.sv]
// Hex command frame parser: frames received bytes as a command character plus four
// hex digits and reports parsed commands, echoes and errors.
// Depends on hcfp_pkg, hcfp_in_if, hcfp_out_if and hcfp_parse.
//
// Usage:
//   in_ch   carries one received byte per transfer (rx_byte).
//   out_ch  carries one result per transfer: kind, command, value, echo frame and
//           last_of_run, which marks the final result caused by one input byte.
//   cfg_we/cfg_wdata write echo_enable; write only while the block is idle.
// Timing:
//   A byte is registered on its transfer and decoded into the output register once
//   that register is free and no result is pending, so its first result is offered
//   from the output register.
//   One byte is taken per cycle while the output is free and no result is pending.
//   A frame-ending byte with echo enabled yields two results, held in the output
//   register and one pending register; decode stalls until the pending one moves.
// Reset: frame position returns to waiting for a command, echo is off, no results.
// Stall: while out_ch is not ready the output and pending registers hold, the
//   input register fills, and in_ch ready drops.
module hex_command_frame_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  hcfp_in_if.sink    in_ch,
  hcfp_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import hcfp_pkg::*;

  logic         in_v_r;
  logic [7:0]   in_byte_r;
  logic         echo_en_r;
  logic         out_v_r;
  hcfp_result_t out_res_r;
  logic         pend_v_r;
  hcfp_result_t pend_res_r;
  logic         out_free;
  logic         go;
  hcfp_step_t   step_res;

  assign out_free    = !out_v_r || out_ch.ready;
  assign go          = in_v_r && !pend_v_r && out_free;
  assign in_ch.ready = !in_v_r || go;

  hcfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (go),
    .rx_byte (in_byte_r),
    .echo_en (echo_en_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      echo_en_r <= 1'b0;
      out_v_r   <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        echo_en_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      priority if (pend_v_r && out_free) begin
        out_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
      end else if (go && step_res.count != 2'd0) begin
        out_v_r  <= 1'b1;
        pend_v_r <= (step_res.count == 2'd2);
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    priority if (pend_v_r && out_free) begin
      out_res_r <= pend_res_r;
    end else if (go && step_res.count != 2'd0) begin
      out_res_r  <= step_res.first;
      pend_res_r <= step_res.second;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.result_kind   = out_res_r.kind;
  assign out_ch.command_char  = out_res_r.cmd;
  assign out_ch.command_value = out_res_r.value;
  assign out_ch.echo_frame    = out_res_r.frame;
  assign out_ch.last_of_run   = out_res_r.last;

endmodule
